/* rtl/assert_macros.svh */
// Assertion shorthands shared by the RTL files of the rotation matrix core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AAR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define AAR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/aar_pkg.sv */
// Shared types, constants and tables of the rotation matrix core.
`default_nettype none

package aar_pkg;

   // angle format
   localparam int HALF_TURN_DEG       = 180;
   localparam int ANGLE_FRAC          = 64;
   localparam int FULL_TURN           = 2 * HALF_TURN_DEG * ANGLE_FRAC;
   localparam int QUARTER_TURN        = FULL_TURN / 4;
   localparam int ZRED_W              = 14;

   // sine/cosine iterations
   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int MAX_STEPS           = 24;
   localparam int CZ_W                = 25;
   localparam int ONE_Q28             = 1 << 28;
   localparam int ONE_Q14             = 16384;
   localparam int CORDIC_X0           = 163008218;

   // normalization pipeline
   localparam int ROOT_STEPS          = 31;
   localparam int DIV_STEPS           = 48;
   localparam int DIV_REM0            = 1 << 14;
   localparam int UNIT_LAT            = 1 + ROOT_STEPS + DIV_STEPS + 1;
   localparam int MATRIX_LAT          = 3;

   localparam int QUEUE_DEPTH         = 4;

   typedef logic signed [31:0] q28_type;

   typedef struct packed {
      logic signed [16:0] angle_deg;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r0c0;
      logic signed [15:0] r0c1;
      logic signed [15:0] r0c2;
      logic signed [15:0] r1c0;
      logic signed [15:0] r1c1;
      logic signed [15:0] r1c2;
      logic signed [15:0] r2c0;
      logic signed [15:0] r2c1;
      logic signed [15:0] r2c2;
      logic               zero_axis;
   } rsp_type;

   // classified word held in the queue
   typedef struct packed {
      logic signed [ZRED_W-1:0] zred;
      logic                     neg;
      logic                     zero;
      logic signed [15:0]       axis_x;
      logic signed [15:0]       axis_y;
      logic signed [15:0]       axis_z;
      logic [30:0]              sq_x;
      logic [30:0]              sq_y;
      logic [30:0]              sq_z;
   } work_type;

   typedef struct packed {
      q28_type c;
      q28_type s;
      q28_type t;
   } trig_type;

   typedef struct packed {
      q28_type ux;
      q28_type uy;
      q28_type uz;
      logic    zero;
   } unit_type;

   // atan(2^-i) in units of 2^-16 degree
   function automatic logic signed [CZ_W-1:0] atan_q16(input int idx);
      int v;
      unique case (idx)
         0:       v = 2949120;
         1:       v = 1740967;
         2:       v = 919879;
         3:       v = 466945;
         4:       v = 234379;
         5:       v = 117304;
         6:       v = 58666;
         7:       v = 29335;
         8:       v = 14668;
         9:       v = 7334;
         10:      v = 3667;
         11:      v = 1833;
         12:      v = 917;
         13:      v = 458;
         14:      v = 229;
         15:      v = 115;
         16:      v = 57;
         17:      v = 29;
         18:      v = 14;
         19:      v = 7;
         20:      v = 4;
         21:      v = 2;
         22:      v = 1;
         default: v = 0;
      endcase
      return CZ_W'(v);
   endfunction

endpackage

`default_nettype wire

/* rtl/aar_if.sv */
// Request and response channel interfaces of the rotation matrix core.
`default_nettype none

interface aar_req_if;
   logic             valid;
   logic             ready;
   aar_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface aar_rsp_if;
   logic             valid;
   logic             ready;
   aar_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/aar_front.sv */
// Front end: angle reduction, axis squares, zero test and the word queue.
`default_nettype none
`include "assert_macros.svh"

module aar_front (
   input  logic              clock,
   input  logic              reset,
   aar_req_if.sink           req_if,
   input  logic              pop,
   output logic              head_valid,
   output aar_pkg::work_type head
);

   localparam int DEPTH   = aar_pkg::QUEUE_DEPTH;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FULL    = aar_pkg::FULL_TURN;
   localparam int QUARTER = aar_pkg::QUARTER_TURN;
   localparam int BIAS    = 3 * FULL;

   aar_pkg::work_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic               push;
   logic signed [18:0] biased;
   logic [17:0]        wrapped;
   logic [14:0]        rem;
   logic signed [15:0] zfold;
   logic               neg;
   logic signed [15:0] ax, ay, az;
   logic signed [31:0] px, py, pz;
   aar_pkg::work_type  work;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   // reduce into [0, 360) deg, then fold into [-90, 90] with a sign flag
   always_comb begin
      biased  = {{2{req_if.payload.angle_deg[16]}}, req_if.payload.angle_deg} + 19'(BIAS);
      wrapped = biased[17:0];
      priority if (wrapped >= 18'(5 * FULL)) begin
         rem = 15'(wrapped - 18'(5 * FULL));
      end else if (wrapped >= 18'(4 * FULL)) begin
         rem = 15'(wrapped - 18'(4 * FULL));
      end else if (wrapped >= 18'(3 * FULL)) begin
         rem = 15'(wrapped - 18'(3 * FULL));
      end else if (wrapped >= 18'(2 * FULL)) begin
         rem = 15'(wrapped - 18'(2 * FULL));
      end else if (wrapped >= 18'(FULL)) begin
         rem = 15'(wrapped - 18'(FULL));
      end else begin
         rem = wrapped[14:0];
      end
      priority if (rem <= 15'(QUARTER)) begin
         zfold = {1'b0, rem};
         neg   = 1'b0;
      end else if (rem <= 15'(3 * QUARTER)) begin
         zfold = {1'b0, rem} - 16'(2 * QUARTER);
         neg   = 1'b1;
      end else begin
         zfold = {1'b0, rem} - 16'(FULL);
         neg   = 1'b0;
      end
   end

   always_comb begin
      ax = req_if.payload.axis_x;
      ay = req_if.payload.axis_y;
      az = req_if.payload.axis_z;
      px = 32'(ax) * 32'(ax);
      py = 32'(ay) * 32'(ay);
      pz = 32'(az) * 32'(az);
      work.zred   = zfold[aar_pkg::ZRED_W-1:0];
      work.neg    = neg;
      work.zero   = (ax == '0) && (ay == '0) && (az == '0);
      work.axis_x = ax;
      work.axis_y = ay;
      work.axis_z = az;
      work.sq_x   = px[30:0];
      work.sq_y   = py[30:0];
      work.sq_z   = pz[30:0];
   end

   assign req_if.ready = (count_ff != CNT_W'(DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign head_valid   = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= work;
      end
   end

   `AAR_ASSERT_ALWAYS(a_queue_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `AAR_ASSERT_IMPLY(a_pop_needs_word, clock, reset, pop, count_ff != '0, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/aar_cordic.sv */
// Pipelined rotation-mode CORDIC for cosine/sine, with alignment delay.
`default_nettype none

module aar_cordic #(
   parameter int TRIG_ITERATIONS = aar_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [aar_pkg::ZRED_W-1:0] zred,
   input  logic                            neg,
   output aar_pkg::trig_type               trig
);

   localparam int CZ_W = aar_pkg::CZ_W;
   // delay so that cos/sin meet the unit vector
   localparam int DLY  = aar_pkg::UNIT_LAT - TRIG_ITERATIONS - 1;

   typedef struct packed {
      aar_pkg::q28_type       x;
      aar_pkg::q28_type       y;
      logic signed [CZ_W-1:0] z;
      logic                   neg;
   } cordic_type;

   cordic_type        step_ff [TRIG_ITERATIONS];
   cordic_type        step_in [TRIG_ITERATIONS];
   cordic_type        seed;
   aar_pkg::trig_type trig_ff, trig_in;
   aar_pkg::trig_type dly_ff [DLY];

   function automatic cordic_type cordic_step(input cordic_type s, input int i);
      cordic_type       o;
      aar_pkg::q28_type dx, dy;
      dx    = s.y >>> i;
      dy    = s.x >>> i;
      o.neg = s.neg;
      if (!s.z[CZ_W-1]) begin
         o.x = s.x - dx;
         o.y = s.y + dy;
         o.z = s.z - aar_pkg::atan_q16(i);
      end else begin
         o.x = s.x + dx;
         o.y = s.y - dy;
         o.z = s.z + aar_pkg::atan_q16(i);
      end
      return o;
   endfunction

   function automatic aar_pkg::q28_type clamp_q28(input aar_pkg::q28_type v);
      aar_pkg::q28_type r;
      if (v > aar_pkg::ONE_Q28) begin
         r = aar_pkg::ONE_Q28;
      end else if (v < -aar_pkg::ONE_Q28) begin
         r = -aar_pkg::ONE_Q28;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      seed.x     = aar_pkg::CORDIC_X0;
      seed.y     = '0;
      seed.z     = {{(CZ_W - aar_pkg::ZRED_W - 10){zred[aar_pkg::ZRED_W-1]}}, zred, 10'b0};
      seed.neg   = neg;
      step_in[0] = cordic_step(seed, 0);
      for (int i = 1; i < TRIG_ITERATIONS; i++) begin
         step_in[i] = cordic_step(step_ff[i-1], i);
      end
   end

   // quadrant sign, clamp, and 1 - cos for the outer-product term
   always_comb begin
      if (step_ff[TRIG_ITERATIONS-1].neg) begin
         trig_in.c = clamp_q28(-step_ff[TRIG_ITERATIONS-1].x);
         trig_in.s = clamp_q28(-step_ff[TRIG_ITERATIONS-1].y);
      end else begin
         trig_in.c = clamp_q28(step_ff[TRIG_ITERATIONS-1].x);
         trig_in.s = clamp_q28(step_ff[TRIG_ITERATIONS-1].y);
      end
      trig_in.t = aar_pkg::ONE_Q28 - trig_in.c;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff   <= step_in;
         trig_ff   <= trig_in;
         dly_ff[0] <= trig_ff;
         for (int k = 1; k < DLY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign trig = dly_ff[DLY-1];

endmodule

`default_nettype wire

/* rtl/aar_unit.sv */
// Axis normalization: digit-serial square root, reciprocal and scaling pipeline.
`default_nettype none

module aar_unit (
   input  logic              clock,
   input  logic              en,
   input  aar_pkg::work_type head,
   output aar_pkg::unit_type unit
);

   localparam int ROOT_STEPS = aar_pkg::ROOT_STEPS;
   localparam int DIV_STEPS  = aar_pkg::DIV_STEPS;
   localparam int AXIS_DLY   = 1 + ROOT_STEPS + DIV_STEPS;

   typedef struct packed {
      logic [31:0] rad;
      logic [32:0] rem;
      logic [30:0] root;
   } root_type;

   typedef struct packed {
      logic [30:0] den;
      logic [30:0] rem;
      logic [47:0] quo;
   } div_type;

   typedef struct packed {
      logic               zero;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } axis_type;

   logic [31:0]       n2_ff;
   root_type          root_ff [ROOT_STEPS];
   root_type          root_in [ROOT_STEPS];
   root_type          root_seed;
   div_type           div_ff [DIV_STEPS];
   div_type           div_in [DIV_STEPS];
   div_type           div_seed;
   axis_type          axis_ff [AXIS_DLY];
   aar_pkg::unit_type unit_ff, unit_in;

   // one result bit per step
   function automatic root_type root_step(input root_type s);
      root_type    o;
      logic [34:0] rem_x, trial, diff;
      rem_x = {s.rem, s.rad[31:30]};
      trial = {2'b00, s.root, 2'b01};
      diff  = rem_x - trial;
      o.rad = {s.rad[29:0], 2'b00};
      if (rem_x >= trial) begin
         o.rem  = diff[32:0];
         o.root = {s.root[29:0], 1'b1};
      end else begin
         o.rem  = rem_x[32:0];
         o.root = {s.root[29:0], 1'b0};
      end
      return o;
   endfunction

   // restoring division, one quotient bit per step
   function automatic div_type div_step(input div_type s);
      div_type     o;
      logic [31:0] r2, diff;
      r2    = {s.rem, 1'b0};
      diff  = r2 - {1'b0, s.den};
      o.den = s.den;
      if (r2 >= {1'b0, s.den}) begin
         o.rem = diff[30:0];
         o.quo = {s.quo[46:0], 1'b1};
      end else begin
         o.rem = r2[30:0];
         o.quo = {s.quo[46:0], 1'b0};
      end
      return o;
   endfunction

   function automatic aar_pkg::q28_type scale(input logic signed [15:0] a, input logic [47:0] rs);
      logic signed [64:0] prod, sum;
      prod = $signed({{49{a[15]}}, a}) * $signed({17'b0, rs});
      sum  = prod + 65'sd262144;
      return sum[50:19];
   endfunction

   always_comb begin
      root_seed.rad  = n2_ff;
      root_seed.rem  = '0;
      root_seed.root = '0;
      root_in[0]     = root_step(root_seed);
      for (int j = 1; j < ROOT_STEPS; j++) begin
         root_in[j] = root_step(root_ff[j-1]);
      end
      div_seed.den = root_ff[ROOT_STEPS-1].root;
      div_seed.rem = 31'(aar_pkg::DIV_REM0);
      div_seed.quo = '0;
      div_in[0]    = div_step(div_seed);
      for (int j = 1; j < DIV_STEPS; j++) begin
         div_in[j] = div_step(div_ff[j-1]);
      end
      unit_in.ux   = scale(axis_ff[AXIS_DLY-1].ax, div_ff[DIV_STEPS-1].quo);
      unit_in.uy   = scale(axis_ff[AXIS_DLY-1].ay, div_ff[DIV_STEPS-1].quo);
      unit_in.uz   = scale(axis_ff[AXIS_DLY-1].az, div_ff[DIV_STEPS-1].quo);
      unit_in.zero = axis_ff[AXIS_DLY-1].zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff           <= {1'b0, head.sq_x} + {1'b0, head.sq_y} + {1'b0, head.sq_z};
         root_ff         <= root_in;
         div_ff          <= div_in;
         unit_ff         <= unit_in;
         axis_ff[0].zero <= head.zero;
         axis_ff[0].ax   <= head.axis_x;
         axis_ff[0].ay   <= head.axis_y;
         axis_ff[0].az   <= head.axis_z;
         for (int k = 1; k < AXIS_DLY; k++) begin
            axis_ff[k] <= axis_ff[k-1];
         end
      end
   end

   assign unit = unit_ff;

endmodule

`default_nettype wire

/* rtl/aar_matrix.sv */
// Rodrigues matrix assembly: products, scaling by 1 - cos, sums and Q1.14 output.
`default_nettype none

module aar_matrix (
   input  logic              clock,
   input  logic              en,
   input  aar_pkg::trig_type trig,
   input  aar_pkg::unit_type unit,
   output aar_pkg::rsp_type  rsp
);

   typedef aar_pkg::q28_type q28_type;

   // stage 1
   q28_type p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff, p_yz_ff;
   q28_type s_x_ff, s_y_ff, s_z_ff, c1_ff, t1_ff;
   logic    zero1_ff;
   // stage 2
   q28_type w_xx_ff, w_yy_ff, w_zz_ff, w_xy_ff, w_xz_ff, w_yz_ff;
   q28_type s2x_ff, s2y_ff, s2z_ff, c2_ff;
   logic    zero2_ff;
   // stage 3
   aar_pkg::rsp_type rsp_ff, rsp_in;

   function automatic q28_type mul28(input q28_type a, input q28_type b);
      logic signed [63:0] prod, sum;
      prod = 64'(a) * 64'(b);
      sum  = prod + 64'sd134217728;
      return sum[59:28];
   endfunction

   function automatic logic signed [32:0] add33(input q28_type a, input q28_type b);
      return {a[31], a} + {b[31], b};
   endfunction

   function automatic logic signed [32:0] sub33(input q28_type a, input q28_type b);
      return {a[31], a} - {b[31], b};
   endfunction

   function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
      logic signed [33:0] sum;
      logic signed [19:0] q;
      logic signed [15:0] r;
      sum = {v[32], v} + 34'sd8192;
      q   = sum[33:14];
      if (q > 20'sd16384) begin
         r = 16'sd16384;
      end else if (q < -20'sd16384) begin
         r = -16'sd16384;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

   always_comb begin
      if (zero2_ff) begin
         rsp_in.r0c0 = 16'(aar_pkg::ONE_Q14);
         rsp_in.r0c1 = '0;
         rsp_in.r0c2 = '0;
         rsp_in.r1c0 = '0;
         rsp_in.r1c1 = 16'(aar_pkg::ONE_Q14);
         rsp_in.r1c2 = '0;
         rsp_in.r2c0 = '0;
         rsp_in.r2c1 = '0;
         rsp_in.r2c2 = 16'(aar_pkg::ONE_Q14);
      end else begin
         rsp_in.r0c0 = to_q14(add33(w_xx_ff, c2_ff));
         rsp_in.r0c1 = to_q14(sub33(w_xy_ff, s2z_ff));
         rsp_in.r0c2 = to_q14(add33(w_xz_ff, s2y_ff));
         rsp_in.r1c0 = to_q14(add33(w_xy_ff, s2z_ff));
         rsp_in.r1c1 = to_q14(add33(w_yy_ff, c2_ff));
         rsp_in.r1c2 = to_q14(sub33(w_yz_ff, s2x_ff));
         rsp_in.r2c0 = to_q14(sub33(w_xz_ff, s2y_ff));
         rsp_in.r2c1 = to_q14(add33(w_yz_ff, s2x_ff));
         rsp_in.r2c2 = to_q14(add33(w_zz_ff, c2_ff));
      end
      rsp_in.zero_axis = zero2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_xx_ff  <= mul28(unit.ux, unit.ux);
         p_yy_ff  <= mul28(unit.uy, unit.uy);
         p_zz_ff  <= mul28(unit.uz, unit.uz);
         p_xy_ff  <= mul28(unit.ux, unit.uy);
         p_xz_ff  <= mul28(unit.ux, unit.uz);
         p_yz_ff  <= mul28(unit.uy, unit.uz);
         s_x_ff   <= mul28(trig.s, unit.ux);
         s_y_ff   <= mul28(trig.s, unit.uy);
         s_z_ff   <= mul28(trig.s, unit.uz);
         c1_ff    <= trig.c;
         t1_ff    <= trig.t;
         zero1_ff <= unit.zero;

         w_xx_ff  <= mul28(p_xx_ff, t1_ff);
         w_yy_ff  <= mul28(p_yy_ff, t1_ff);
         w_zz_ff  <= mul28(p_zz_ff, t1_ff);
         w_xy_ff  <= mul28(p_xy_ff, t1_ff);
         w_xz_ff  <= mul28(p_xz_ff, t1_ff);
         w_yz_ff  <= mul28(p_yz_ff, t1_ff);
         s2x_ff   <= s_x_ff;
         s2y_ff   <= s_y_ff;
         s2z_ff   <= s_z_ff;
         c2_ff    <= c1_ff;
         zero2_ff <= zero1_ff;

         rsp_ff   <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

/* rtl/axis_angle_rotation_matrix_core.sv */
// Top level of the axis-angle (Rodrigues) rotation matrix core.
// An accepted request word goes through the queue and the 84 back stages to become its response word.
// Throughput: one word per cycle while responses are taken; the back pipeline advances whenever its output is free.
// The 84 stages: 81-stage normalization path (sum, 31 root, 48 reciprocal, scale) + 3 matrix.
// Reset (synchronous, active high) empties the queue and clears all valid flags.
`default_nettype none
`include "assert_macros.svh"

module axis_angle_rotation_matrix_core #(
   parameter int TRIG_ITERATIONS = aar_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   aar_req_if.sink    req_if,
   aar_rsp_if.source  rsp_if
);

   // Back pipeline depth: normalization unit plus matrix assembly. The CORDIC
   // runs alongside and is delayed inside its module to meet the unit vector.
   localparam int BACK_LAT = aar_pkg::UNIT_LAT + aar_pkg::MATRIX_LAT;

   logic              head_valid;
   aar_pkg::work_type head;
   logic              en;
   logic              take;
   aar_pkg::trig_type trig;
   aar_pkg::unit_type unit;
   aar_pkg::rsp_type  rsp;

   // one valid flag per back stage
   logic [BACK_LAT-1:0] vld_ff, vld_in;

   // Front: classify each request word (angle fold, axis squares, zero test)
   // and hold it in a four-word queue so the input keeps flowing until the
   // queue fills while the response side stalls.
   aar_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .pop        (take),
      .head_valid (head_valid),
      .head       (head)
   );

   // The whole back pipeline moves as one; it stops only when a finished
   // response word sits in the output register and is not being taken.
   assign en   = !vld_ff[BACK_LAT-1] || rsp_if.ready;
   assign take = en && head_valid;

   // cos, sin and 1 - cos, aligned to the unit vector
   aar_cordic #(
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .en    (en),
      .zred  (head.zred),
      .neg   (head.neg),
      .trig  (trig)
   );

   // unit axis: |a|^2 -> isqrt(|a|^2 * 2^30) -> 2^62 / root -> scale each component
   aar_unit u_unit (
      .clock (clock),
      .en    (en),
      .head  (head),
      .unit  (unit)
   );

   // R = c*I + (1-c)*u*u^T + s*[u]x, identity for a zero axis
   aar_matrix u_matrix (
      .clock (clock),
      .en    (en),
      .trig  (trig),
      .unit  (unit),
      .rsp   (rsp)
   );

   always_comb begin
      if (en) begin
         vld_in = {vld_ff[BACK_LAT-2:0], take};
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_if.valid   = vld_ff[BACK_LAT-1];
   assign rsp_if.payload = rsp;

   // a zero axis must come out as the identity; checks the diagonal, r0c1, r1c2 and r2c0
   `AAR_ASSERT_IMPLY(a_zero_axis_identity, clock, reset, rsp_if.valid && rsp_if.payload.zero_axis, (rsp_if.payload.r0c0 == aar_pkg::ONE_Q14) && (rsp_if.payload.r1c1 == aar_pkg::ONE_Q14) && (rsp_if.payload.r2c2 == aar_pkg::ONE_Q14) && (rsp_if.payload.r0c1 == 0) && (rsp_if.payload.r1c2 == 0) && (rsp_if.payload.r2c0 == 0), "zero axis without identity")
   // entries r0c0 and r2c1 stay inside the Q1.14 unit range
   `AAR_ASSERT_IMPLY(a_entry_range, clock, reset, rsp_if.valid, (rsp_if.payload.r0c0 <= aar_pkg::ONE_Q14) && (rsp_if.payload.r0c0 >= -aar_pkg::ONE_Q14) && (rsp_if.payload.r2c1 <= aar_pkg::ONE_Q14) && (rsp_if.payload.r2c1 >= -aar_pkg::ONE_Q14), "matrix entry out of range")

endmodule

`default_nettype wire

/* tb/aar_tb_if.sv */
// Channel interfaces used by the testbench (valid/ready handshake with typed payload).
// The RTL's own interfaces are used directly; this file holds the timescale and the watchdog limit.
`default_nettype none

package aar_tb_types;
   timeunit 1ns;
   timeprecision 1ps;
   localparam int WATCHDOG_LIMIT = 20000;
endpackage

`default_nettype wire

/* tb/rotation_checker.sv */
// Checker: predicts each rotation matrix from accepted request words and compares responses.
`default_nettype none

module rotation_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  aar_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  aar_pkg::rsp_type rsp_word,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRIG_STEPS = aar_pkg::TRIG_ITERATIONS_DEF;

   aar_pkg::rsp_type matrix_queue[$];

   function automatic longint floor_shift(input longint v, input int sh);
      return v >>> sh;
   endfunction

   function automatic longint round_shift(input longint v, input int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint q28_mul(input longint a, input longint b);
      return round_shift(a * b, 28);
   endfunction

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint step_angle(input int i);
      longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                          14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      return tbl[i];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [15:0] to_entry(input longint v);
      return 16'(limit(round_shift(v, 14), -aar_pkg::ONE_Q14, aar_pkg::ONE_Q14));
   endfunction

   function automatic aar_pkg::rsp_type rotation_matrix(input aar_pkg::req_type w);
      aar_pkg::rsp_type res;
      longint ang, ax, ay, az, r, z, x, y, c, s, t, ux, uy, uz, dx, dy;
      longint unsigned n2, sq, rs;
      longint m[9];
      bit neg;
      int steps;
      ang = w.angle_deg; ax = w.axis_x; ay = w.axis_y; az = w.axis_z;
      neg = 0;
      res = '0;
      if (ax == 0 && ay == 0 && az == 0) begin
         res.r0c0 = 16'(aar_pkg::ONE_Q14);
         res.r1c1 = 16'(aar_pkg::ONE_Q14);
         res.r2c2 = 16'(aar_pkg::ONE_Q14);
         res.zero_axis = 1'b1;
         return res;
      end
      r = ang % aar_pkg::FULL_TURN;
      if (r < 0) r += aar_pkg::FULL_TURN;
      if (r <= aar_pkg::QUARTER_TURN) begin
         z = r;
      end else if (r <= 3 * aar_pkg::QUARTER_TURN) begin
         z = r - aar_pkg::HALF_TURN_DEG * aar_pkg::ANGLE_FRAC;
         neg = 1;
      end else begin
         z = r - aar_pkg::FULL_TURN;
      end
      z = z * 1024;
      steps = TRIG_STEPS > aar_pkg::MAX_STEPS ? aar_pkg::MAX_STEPS : TRIG_STEPS;
      x = aar_pkg::CORDIC_X0;
      y = 0;
      for (int i = 0; i < steps; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= step_angle(i);
         end else begin
            x += dx; y -= dy; z += step_angle(i);
         end
      end
      if (neg) begin
         x = -x; y = -y;
      end
      c = limit(x, -(longint'(1) << 28), longint'(1) << 28);
      s = limit(y, -(longint'(1) << 28), longint'(1) << 28);
      t = (longint'(1) << 28) - c;
      n2 = ax * ax + ay * ay + az * az;
      sq = int_sqrt(n2 << 30);
      rs = (64'd1 << 62) / sq;
      ux = round_shift(ax * longint'(rs), 19);
      uy = round_shift(ay * longint'(rs), 19);
      uz = round_shift(az * longint'(rs), 19);
      m[0] = q28_mul(q28_mul(ux, ux), t) + c;
      m[1] = q28_mul(q28_mul(uy, ux), t) - q28_mul(s, uz);
      m[2] = q28_mul(q28_mul(uz, ux), t) + q28_mul(s, uy);
      m[3] = q28_mul(q28_mul(ux, uy), t) + q28_mul(s, uz);
      m[4] = q28_mul(q28_mul(uy, uy), t) + c;
      m[5] = q28_mul(q28_mul(uz, uy), t) - q28_mul(s, ux);
      m[6] = q28_mul(q28_mul(ux, uz), t) - q28_mul(s, uy);
      m[7] = q28_mul(q28_mul(uy, uz), t) + q28_mul(s, ux);
      m[8] = q28_mul(q28_mul(uz, uz), t) + c;
      res.r0c0 = to_entry(m[0]); res.r0c1 = to_entry(m[1]); res.r0c2 = to_entry(m[2]);
      res.r1c0 = to_entry(m[3]); res.r1c1 = to_entry(m[4]); res.r1c2 = to_entry(m[5]);
      res.r2c0 = to_entry(m[6]); res.r2c1 = to_entry(m[7]); res.r2c2 = to_entry(m[8]);
      res.zero_axis = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = matrix_queue.size();

   always @(posedge clock) begin
      aar_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            matrix_queue.push_back(rotation_matrix(req_word));
         if (rsp_valid && rsp_ready) begin
            if (matrix_queue.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = matrix_queue.pop_front();
               if (rsp_word.r0c0 !== want.r0c0) report_mismatch("r0c0", rsp_word.r0c0, want.r0c0);
               if (rsp_word.r0c1 !== want.r0c1) report_mismatch("r0c1", rsp_word.r0c1, want.r0c1);
               if (rsp_word.r0c2 !== want.r0c2) report_mismatch("r0c2", rsp_word.r0c2, want.r0c2);
               if (rsp_word.r1c0 !== want.r1c0) report_mismatch("r1c0", rsp_word.r1c0, want.r1c0);
               if (rsp_word.r1c1 !== want.r1c1) report_mismatch("r1c1", rsp_word.r1c1, want.r1c1);
               if (rsp_word.r1c2 !== want.r1c2) report_mismatch("r1c2", rsp_word.r1c2, want.r1c2);
               if (rsp_word.r2c0 !== want.r2c0) report_mismatch("r2c0", rsp_word.r2c0, want.r2c0);
               if (rsp_word.r2c1 !== want.r2c1) report_mismatch("r2c1", rsp_word.r2c1, want.r2c1);
               if (rsp_word.r2c2 !== want.r2c2) report_mismatch("r2c2", rsp_word.r2c2, want.r2c2);
               if (rsp_word.zero_axis !== want.zero_axis)
                  report_mismatch("zero_axis", rsp_word.zero_axis, want.zero_axis);
            end
         end
      end
   end
endmodule

`default_nettype wire

/* tb/testbench.sv */
// Top of the rotation matrix testbench: clock, reset, stimulus phases and verdict.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // drain margin well beyond the pipeline depth plus the small queue
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_WORDS = 1385;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   quiet_cycles;

   // idle percentages, changed per phase by the stimulus
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_off;        // long receiver hold-off in progress

   aar_req_if req_ch();
   aar_rsp_if rsp_ch();

   axis_angle_rotation_matrix_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   rotation_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_word      (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_word      (rsp_ch.payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // receiver: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= aar_tb_types::WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // offer one word, holding valid until accepted; random gaps come first
   task automatic send_word(input aar_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // back-to-back variant: leaves valid high for the next word
   task automatic send_stream(input aar_pkg::req_type w);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic signed [15:0] axis_value();
      case ($urandom_range(5))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2:       return 16'($urandom_range(4) - 2);
         3:       return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic aar_pkg::req_type random_word();
      aar_pkg::req_type w;
      w.angle_deg = 17'($urandom);
      case ($urandom_range(3))
         0: w.angle_deg = 17'(($urandom_range(8) * aar_pkg::QUARTER_TURN)
                              + $urandom_range(2) - 1);
         1: w.angle_deg = -w.angle_deg;
         default: ;
      endcase
      w.axis_x = axis_value();
      w.axis_y = axis_value();
      w.axis_z = axis_value();
      if ($urandom_range(40) == 0) begin
         w.axis_x = '0; w.axis_y = '0; w.axis_z = '0;
      end
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int phase_len;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off       = 1'b0;
      @(negedge reset);
      @(posedge clock);

      // directed: zero axis, field extremes, quadrant edges, wraps and negatives
      send_word('{angle_deg: 17'sd1234,  axis_x: 0, axis_y: 0, axis_z: 0});
      send_word('{angle_deg: 17'sd0,     axis_x: 1, axis_y: 0, axis_z: 0});
      send_word('{angle_deg: 17'sd5760,  axis_x: 0, axis_y: 1, axis_z: 0});
      send_word('{angle_deg: 17'sd5761,  axis_x: 0, axis_y: 0, axis_z: 1});
      send_word('{angle_deg: 17'sd11520, axis_x: 5, axis_y: 5, axis_z: 5});
      send_word('{angle_deg: 17'sd17280, axis_x: -3, axis_y: 4, axis_z: 0});
      send_word('{angle_deg: 17'sd17281, axis_x: 16'sh7FFF, axis_y: 16'sh7FFF,
                  axis_z: 16'sh7FFF});
      send_word('{angle_deg: 17'sd23039, axis_x: -16'sh8000, axis_y: -16'sh8000,
                  axis_z: -16'sh8000});
      send_word('{angle_deg: 17'sd23040, axis_x: -16'sh8000, axis_y: 0, axis_z: 0});
      send_word('{angle_deg: 17'sd65535, axis_x: 16'sh7FFF, axis_y: -1, axis_z: 1});
      send_word('{angle_deg: 17'h10000, axis_x: 0, axis_y: -16'sh8000, axis_z: 16'sh7FFF});
      send_word('{angle_deg: -17'sd1,    axis_x: 1, axis_y: 1, axis_z: 1});
      send_word('{angle_deg: -17'sd5760, axis_x: 0, axis_y: 0, axis_z: -1});
      send_word('{angle_deg: -17'sd23041, axis_x: 100, axis_y: -200, axis_z: 300});
      send_word('{angle_deg: 17'sd2880,  axis_x: 1, axis_y: 0, axis_z: 0});

      // pressure: receiver holds off while the sender keeps offering
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 150 && hold_off; i++) send_stream(random_word());
            req_ch.valid <= 1'b0;
         end
      join
      // pause until everything is back
      wait_drained();

      // random phases with varied idling; last one cycles back to no idling
      phase_len = RANDOM_WORDS / 5;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            3: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int i = 0; i < phase_len; i++) begin
            if (send_idle_pct == 0) begin
               send_stream(random_word());
            end else begin
               send_word(random_word());
            end
         end
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end

      recv_stall_pct = 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/aar_pkg.sv
rtl/aar_if.sv
rtl/aar_front.sv
rtl/aar_cordic.sv
rtl/aar_unit.sv
rtl/aar_matrix.sv
rtl/axis_angle_rotation_matrix_core.sv
tb/aar_tb_if.sv
tb/rotation_checker.sv
tb/testbench.sv
